FILE: hdl/assert_macros.svh
// Assertion macros shared by the checker files.
// No dependencies.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled in reset.
`define HLAC_ASSERT_IMP(label, clk, rst_n, pre, post) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (pre) |-> (post)) \
    else $error("assertion failed");

// Next-cycle implication, disabled in reset.
`define HLAC_ASSERT_NXT(label, clk, rst_n, pre, post) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (pre) |=> (post)) \
    else $error("assertion failed");

`endif

FILE: hdl/hlac_pkg.sv
// Types and constants of the Huffman length anomaly check.
// No dependencies.
`default_nettype none

package hlac_pkg;

  localparam int unsigned NSYM   = 16;
  localparam int unsigned NNODE  = 31;
  localparam int unsigned BITS_W = 36;
  localparam int unsigned SYMS_W = 32;
  localparam int unsigned QDEPTH = 4;
  localparam int unsigned QPTR_W = 2;

  localparam logic [2:0] FUNC_REF_CHAR   = 3'd0;
  localparam logic [2:0] FUNC_REF_CLOSE  = 3'd1;
  localparam logic [2:0] FUNC_TEST_CHAR  = 3'd2;
  localparam logic [2:0] FUNC_TEST_CLOSE = 3'd3;
  localparam logic [2:0] FUNC_CLEAR      = 3'd4;

  localparam logic [1:0] STS_OK      = 2'd0;
  localparam logic [1:0] STS_EMPTY   = 2'd1;
  localparam logic [1:0] STS_NO_CODE = 2'd2;
  localparam logic [1:0] STS_SAT     = 2'd3;

  localparam logic       KIND_REF  = 1'b0;
  localparam logic       KIND_TEST = 1'b1;

  localparam logic       REG_NUM = 1'b0;
  localparam logic       REG_DEN = 1'b1;
  localparam logic [3:0] NUM_RESET = 4'd3;
  localparam logic [3:0] DEN_RESET = 4'd2;

  typedef enum logic [2:0] {
    OP_REF_CHAR,
    OP_REF_CLOSE,
    OP_TEST_CHAR,
    OP_TEST_CLOSE,
    OP_CLEAR
  } op_e;

  typedef struct packed {
    op_e        op;
    logic [3:0] sym;
  } hlac_op_t;

  typedef struct packed {
    logic       hit;
    logic [3:0] sym;
  } hex_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_INIT,
    ST_PLAN,
    ST_SCAN,
    ST_DEPTH,
    ST_SUM,
    ST_REF_RPT,
    ST_MUL,
    ST_TEST_RPT
  } st_e;

  function automatic hex_t hex_sym(input logic [7:0] c);
    hex_t r;
    r.hit = 1'b0;
    r.sym = 4'd0;
    if (c >= 8'h30 && c <= 8'h39) begin
      r.hit = 1'b1;
      r.sym = 4'(c - 8'h30);
    end else if (c >= 8'h41 && c <= 8'h46) begin
      r.hit = 1'b1;
      r.sym = 4'(c - 8'h37);
    end
    return r;
  endfunction

endpackage

`default_nettype wire

FILE: hdl/hlac_front.sv
// Front end: decodes requests and queues the ones that matter.
// Depends on hlac_pkg.
`default_nettype none

module hlac_front import hlac_pkg::*; (
  input  wire logic       clk_i,
  input  wire logic       rst_ni,
  input  wire logic       start_i,
  input  wire logic [2:0] func_i,
  input  wire logic [7:0] char_code_i,
  output logic            busy_o,
  input  wire logic       pop_i,
  output hlac_op_t        head_o,
  output logic            empty_o
);

  hlac_op_t            q_mem [QDEPTH];
  logic [QPTR_W-1:0]   wr_q, rd_q;
  logic [QPTR_W:0]     cnt_q;
  hlac_op_t            dec;
  logic                keep, push;
  hex_t                hx;

  always_comb begin
    hx       = hex_sym(char_code_i);
    dec.sym  = hx.sym;
    dec.op   = OP_CLEAR;
    keep     = 1'b0;
    case (func_i)
      FUNC_REF_CHAR: begin
        dec.op = OP_REF_CHAR;
        keep   = hx.hit;
      end
      FUNC_REF_CLOSE: begin
        dec.op = OP_REF_CLOSE;
        keep   = 1'b1;
      end
      FUNC_TEST_CHAR: begin
        dec.op = OP_TEST_CHAR;
        keep   = hx.hit;
      end
      FUNC_TEST_CLOSE: begin
        dec.op = OP_TEST_CLOSE;
        keep   = 1'b1;
      end
      FUNC_CLEAR: begin
        dec.op = OP_CLEAR;
        keep   = 1'b1;
      end
      default: keep = 1'b0;
    endcase
  end

  assign busy_o  = (cnt_q == (QPTR_W+1)'(QDEPTH));
  assign empty_o = (cnt_q == '0);
  assign push    = start_i && !busy_o && keep;
  assign head_o  = q_mem[rd_q];

  always_ff @(posedge clk_i) begin
    if (push) q_mem[wr_q] <= dec;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      if (push) wr_q <= wr_q + 1'b1;
      if (pop_i) rd_q <= rd_q + 1'b1;
      case ({push, pop_i})
        2'b10:   cnt_q <= cnt_q + 1'b1;
        2'b01:   cnt_q <= cnt_q - 1'b1;
        default: cnt_q <= cnt_q;
      endcase
    end
  end

endmodule

`default_nettype wire

FILE: hdl/hlac_back.sv
// Back end: histogram, Huffman length build, test totals and the ratio compare.
// Depends on hlac_pkg.
`default_nettype none

module hlac_back import hlac_pkg::*; #(
  parameter int unsigned COUNT_BITS = 32
) (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               empty_i,
  input  wire hlac_op_t           head_i,
  output logic                    pop_o,
  input  wire logic [3:0]         num_i,
  input  wire logic [3:0]         den_i,
  output logic                    done_o,
  output logic                    result_kind_o,
  output logic [BITS_W-1:0]       bit_total_o,
  output logic [SYMS_W-1:0]       symbol_total_o,
  output logic                    suspicious_o,
  output logic [1:0]              status_o
);

  localparam int unsigned W  = COUNT_BITS + 4;
  localparam int unsigned PW = ((W > BITS_W) ? W : BITS_W) + 1;
  localparam int unsigned SW = ((COUNT_BITS > SYMS_W) ? COUNT_BITS : SYMS_W) + 1;
  localparam int unsigned AW = BITS_W + 4;
  localparam int unsigned LW = 2 * SYMS_W + 8;

  localparam logic [COUNT_BITS-1:0] CMAX = {COUNT_BITS{1'b1}};
  localparam logic [BITS_W-1:0]     BMAX = {BITS_W{1'b1}};
  localparam logic [SYMS_W-1:0]     SMAX = {SYMS_W{1'b1}};

  st_e state_q, state_d;

  // symbol stores
  logic [COUNT_BITS-1:0] hist_q [NSYM];
  logic [3:0]            len_q  [NSYM];
  logic [NSYM-1:0]       present_q;

  // totals and flags
  logic [BITS_W-1:0] rb_q, tb_q;
  logic [SYMS_W-1:0] rs_q, ts_q;
  logic test_phase_q, ref_empty_q, ref_sat_q, test_sat_q, no_code_q;

  // build state
  logic [W-1:0] nw_q   [NNODE];
  logic [4:0]   npar_q [NNODE];
  logic [NNODE-1:0] nleaf_q, nlive_q, npv_q;
  logic [3:0]   lsym_q [NSYM];
  logic [3:0]   s_q;
  logic [4:0]   n_q, alive_q, nleaves_q, k_q, best_q, pick0_q, leafi_q, node_q;
  logic [W-1:0] bw_q, pw0_q;
  logic         bleaf_q, found_q, pick_q;
  logic [3:0]   d_q;

  // compare datapath
  logic [2:0]        mstep_q;
  logic [AW-1:0]     a_q, c_q;
  logic [2*SYMS_W-1:0] prod_q;
  logic [LW-1:0]     lacc_q, racc_q;

  // result register
  logic              done_q, kind_q, susp_q;
  logic [BITS_W-1:0] obits_q;
  logic [SYMS_W-1:0] osyms_q;
  logic [1:0]        osts_q;

  logic [3:0]            rd_idx;
  logic [COUNT_BITS-1:0] hist_rd;
  logic [3:0]            len_rd;
  logic                  pres_rd;
  logic [W-1:0]          w_rd;
  logic                  take, scan_end, step_up, pv_rd;
  logic [4:0]            par_rd;
  logic [3:0]            lsym_rd;
  logic [BITS_W:0]       tb_sum;
  logic [W-1:0]          prod_len;
  logic [PW-1:0]         rb_sum;
  logic [SW-1:0]         rs_sum;
  logic [SYMS_W-1:0]     mx, my;

  // single read port: the queued symbol when idle, the sweep index otherwise
  assign rd_idx  = (state_q == ST_IDLE) ? head_i.sym : s_q;
  assign hist_rd = hist_q[rd_idx];
  assign len_rd  = len_q[rd_idx];
  assign pres_rd = present_q[rd_idx];

  assign w_rd     = nw_q[k_q];
  assign scan_end = (k_q == n_q);
  assign take     = !scan_end && nlive_q[k_q] &&
                    (!found_q || (w_rd < bw_q) ||
                     ((w_rd == bw_q) && nleaf_q[k_q] && !bleaf_q));

  assign pv_rd   = npv_q[node_q];
  assign par_rd  = npar_q[node_q];
  assign lsym_rd = lsym_q[leafi_q[3:0]];
  assign step_up = pv_rd && (d_q != 4'd15);

  assign tb_sum   = {1'b0, tb_q} + (BITS_W+1)'(len_rd);
  assign prod_len = W'(hist_rd) * W'(len_rd);
  assign rb_sum   = PW'(rb_q) + PW'(prod_len);
  assign rs_sum   = SW'(rs_q) + SW'(hist_rd);

  always_comb begin
    mx = '0;
    my = '0;
    case (mstep_q)
      3'd1: begin mx = a_q[SYMS_W-1:0];              my = rs_q; end
      3'd2: begin mx = SYMS_W'(a_q[AW-1:SYMS_W]);    my = rs_q; end
      3'd3: begin mx = c_q[SYMS_W-1:0];              my = ts_q; end
      3'd4: begin mx = SYMS_W'(c_q[AW-1:SYMS_W]);    my = ts_q; end
      default: begin mx = '0; my = '0; end
    endcase
  end

  // next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE: begin
        if (!empty_i) begin
          case (head_i.op)
            OP_REF_CLOSE:  if (!test_phase_q) state_d = ST_INIT;
            OP_TEST_CLOSE: if (test_phase_q) state_d = ST_MUL;
            default:       state_d = ST_IDLE;
          endcase
        end
      end
      ST_INIT:  if (s_q == 4'd15) state_d = ST_PLAN;
      ST_PLAN: begin
        if (alive_q > 5'd1)          state_d = ST_SCAN;
        else if (nleaves_q == 5'd0)  state_d = ST_SUM;
        else                         state_d = ST_DEPTH;
      end
      ST_SCAN:  if (scan_end && pick_q) state_d = ST_PLAN;
      ST_DEPTH: if (!step_up && (leafi_q == nleaves_q - 5'd1)) state_d = ST_SUM;
      ST_SUM:   if (s_q == 4'd15) state_d = ST_REF_RPT;
      ST_REF_RPT:  state_d = ST_IDLE;
      ST_MUL:   if (mstep_q == 3'd5) state_d = ST_TEST_RPT;
      ST_TEST_RPT: state_d = ST_IDLE;
      default:  state_d = ST_IDLE;
    endcase
  end

  // outputs
  always_comb begin
    pop_o          = (state_q == ST_IDLE) && !empty_i;
    done_o         = done_q;
    result_kind_o  = kind_q;
    bit_total_o    = obits_q;
    symbol_total_o = osyms_q;
    suspicious_o   = susp_q;
    status_o       = osts_q;
  end

  // control, stores and totals
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= ST_IDLE;
      for (int i = 0; i < NSYM; i++) begin
        hist_q[i] <= '0;
        len_q[i]  <= '0;
      end
      present_q    <= '0;
      rb_q         <= '0;
      rs_q         <= '0;
      tb_q         <= '0;
      ts_q         <= '0;
      test_phase_q <= 1'b0;
      ref_empty_q  <= 1'b0;
      ref_sat_q    <= 1'b0;
      test_sat_q   <= 1'b0;
      no_code_q    <= 1'b0;
      s_q          <= '0;
      n_q          <= '0;
      alive_q      <= '0;
      nleaves_q    <= '0;
      k_q          <= '0;
      found_q      <= 1'b0;
      pick_q       <= 1'b0;
      leafi_q      <= '0;
      node_q       <= '0;
      d_q          <= '0;
      mstep_q      <= '0;
      done_q       <= 1'b0;
      kind_q       <= KIND_REF;
      susp_q       <= 1'b0;
      obits_q      <= '0;
      osyms_q      <= '0;
      osts_q       <= STS_OK;
    end else begin
      state_q <= state_d;
      done_q  <= 1'b0;
      case (state_q)
        ST_IDLE: begin
          if (!empty_i) begin
            case (head_i.op)
              OP_REF_CHAR: begin
                if (!test_phase_q) begin
                  if (hist_rd == CMAX) ref_sat_q <= 1'b1;
                  else hist_q[rd_idx] <= hist_rd + 1'b1;
                end
              end
              OP_TEST_CHAR: begin
                if (test_phase_q) begin
                  if (pres_rd) begin
                    if (tb_sum > {1'b0, BMAX}) begin
                      test_sat_q <= 1'b1;
                      tb_q       <= BMAX;
                    end else begin
                      tb_q <= tb_sum[BITS_W-1:0];
                    end
                  end else begin
                    no_code_q <= 1'b1;
                  end
                  if (ts_q == SMAX) test_sat_q <= 1'b1;
                  else ts_q <= ts_q + 1'b1;
                end
              end
              OP_REF_CLOSE: begin
                if (!test_phase_q) begin
                  s_q       <= '0;
                  n_q       <= '0;
                  alive_q   <= '0;
                  nleaves_q <= '0;
                  rb_q      <= '0;
                  rs_q      <= '0;
                  present_q <= '0;
                  for (int i = 0; i < NSYM; i++) len_q[i] <= '0;
                end
              end
              OP_TEST_CLOSE: mstep_q <= '0;
              OP_CLEAR: begin
                for (int i = 0; i < NSYM; i++) begin
                  hist_q[i] <= '0;
                  len_q[i]  <= '0;
                end
                present_q    <= '0;
                rb_q         <= '0;
                rs_q         <= '0;
                tb_q         <= '0;
                ts_q         <= '0;
                test_phase_q <= 1'b0;
                ref_empty_q  <= 1'b0;
                ref_sat_q    <= 1'b0;
                test_sat_q   <= 1'b0;
                no_code_q    <= 1'b0;
              end
              default: ;
            endcase
          end
        end
        ST_INIT: begin
          if (hist_rd != '0) begin
            n_q       <= n_q + 1'b1;
            alive_q   <= alive_q + 1'b1;
            nleaves_q <= nleaves_q + 1'b1;
          end
          s_q <= s_q + 1'b1;
        end
        ST_PLAN: begin
          k_q     <= '0;
          found_q <= 1'b0;
          pick_q  <= 1'b0;
          leafi_q <= '0;
          node_q  <= '0;
          d_q     <= '0;
          s_q     <= '0;
        end
        ST_SCAN: begin
          if (take) found_q <= 1'b1;
          if (!scan_end) begin
            k_q <= k_q + 1'b1;
          end else if (!pick_q) begin
            pick_q  <= 1'b1;
            k_q     <= '0;
            found_q <= 1'b0;
          end else begin
            n_q     <= n_q + 1'b1;
            alive_q <= alive_q - 1'b1;
          end
        end
        ST_DEPTH: begin
          if (step_up) begin
            node_q <= par_rd;
            d_q    <= d_q + 1'b1;
          end else begin
            len_q[lsym_rd]     <= d_q;
            present_q[lsym_rd] <= 1'b1;
            leafi_q            <= leafi_q + 1'b1;
            node_q             <= leafi_q + 1'b1;
            d_q                <= '0;
          end
        end
        ST_SUM: begin
          if (rb_sum > PW'(BMAX)) begin
            ref_sat_q <= 1'b1;
            rb_q      <= BMAX;
          end else begin
            rb_q <= rb_sum[BITS_W-1:0];
          end
          if (rs_sum > SW'(SMAX)) begin
            ref_sat_q <= 1'b1;
            rs_q      <= SMAX;
          end else begin
            rs_q <= rs_sum[SYMS_W-1:0];
          end
          s_q <= s_q + 1'b1;
        end
        ST_REF_RPT: begin
          ref_empty_q  <= (rs_q == '0);
          test_phase_q <= 1'b1;
          done_q       <= 1'b1;
          kind_q       <= KIND_REF;
          obits_q      <= rb_q;
          osyms_q      <= rs_q;
          susp_q       <= 1'b0;
          if (ref_sat_q)         osts_q <= STS_SAT;
          else if (rs_q == '0)   osts_q <= STS_EMPTY;
          else                   osts_q <= STS_OK;
        end
        ST_MUL: mstep_q <= mstep_q + 1'b1;
        ST_TEST_RPT: begin
          done_q  <= 1'b1;
          kind_q  <= KIND_TEST;
          obits_q <= tb_q;
          osyms_q <= ts_q;
          susp_q  <= (lacc_q > racc_q);
          if (ref_sat_q || test_sat_q) osts_q <= STS_SAT;
          else if (no_code_q)          osts_q <= STS_NO_CODE;
          else if (ref_empty_q)        osts_q <= STS_EMPTY;
          else                         osts_q <= STS_OK;
          tb_q       <= '0;
          ts_q       <= '0;
          test_sat_q <= 1'b0;
          no_code_q  <= 1'b0;
        end
        default: ;
      endcase
    end
  end

  // node table and compare datapath
  always_ff @(posedge clk_i) begin
    case (state_q)
      ST_INIT: begin
        if (hist_rd != '0) begin
          nw_q[n_q]         <= W'(hist_rd);
          nleaf_q[n_q]      <= 1'b1;
          nlive_q[n_q]      <= 1'b1;
          npv_q[n_q]        <= 1'b0;
          lsym_q[n_q[3:0]]  <= s_q;
        end
      end
      ST_SCAN: begin
        if (take) begin
          best_q  <= k_q;
          bw_q    <= w_rd;
          bleaf_q <= nleaf_q[k_q];
        end
        if (scan_end) begin
          nlive_q[best_q] <= 1'b0;
          if (!pick_q) begin
            pick0_q <= best_q;
            pw0_q   <= bw_q;
          end else begin
            nw_q[n_q]      <= pw0_q + bw_q;
            nleaf_q[n_q]   <= 1'b0;
            nlive_q[n_q]   <= 1'b1;
            npv_q[n_q]     <= 1'b0;
            npar_q[pick0_q] <= n_q;
            npv_q[pick0_q]  <= 1'b1;
            npar_q[best_q]  <= n_q;
            npv_q[best_q]   <= 1'b1;
          end
        end
      end
      ST_MUL: begin
        if (mstep_q == 3'd0) begin
          a_q <= AW'(den_i) * AW'(tb_q);
          c_q <= AW'(num_i) * AW'(rb_q);
        end
        prod_q <= mx * my;
        case (mstep_q)
          3'd2: lacc_q <= LW'(prod_q);
          3'd3: lacc_q <= lacc_q + {prod_q[LW-SYMS_W-1:0], {SYMS_W{1'b0}}};
          3'd4: racc_q <= LW'(prod_q);
          3'd5: racc_q <= racc_q + {prod_q[LW-SYMS_W-1:0], {SYMS_W{1'b0}}};
          default: ;
        endcase
      end
      default: ;
    endcase
  end

endmodule

`default_nettype wire

FILE: hdl/huffman_length_anomaly_check.sv
// Top level of the Huffman length anomaly check: config registers, front, back.
// Depends on hlac_pkg, hlac_front, hlac_back.
//
//   channel  | signals                                   | handshake
//   ---------+-------------------------------------------+--------------------------
//   request  | func_i, char_code_i                       | start_i high, busy_o low
//   result   | result_kind_o .. status_o                 | done_o, one cycle, no stall
//   config   | psel penable pwrite paddr pwdata           | APB, pready tied high
//
// Chars go one per cycle while busy_o is low, into a four-entry queue;
// busy_o rises only when it is full. Reference close: a leaf pass over every
// symbol, per merge a plan state plus two minimum scans over the nodes, a depth
// walk per present symbol, a sum pass over every symbol and a report.
// Test close: the compare steps of ST_MUL share one 32x32 mul, then a report.
// Reset is asynchronous, active low; done_o pulses one cycle and cannot be held off.
`default_nettype none

module huffman_length_anomaly_check import hlac_pkg::*; #(
  parameter int unsigned COUNT_BITS = 32
) (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              start_i,
  output logic                   busy_o,
  input  wire logic [2:0]        func_i,
  input  wire logic [7:0]        char_code_i,
  output logic                   done_o,
  output logic                   result_kind_o,
  output logic [BITS_W-1:0]      bit_total_o,
  output logic [SYMS_W-1:0]      symbol_total_o,
  output logic                   suspicious_o,
  output logic [1:0]             status_o,
  input  wire logic              psel,
  input  wire logic              penable,
  input  wire logic              pwrite,
  input  wire logic [2:0]        paddr,
  input  wire logic [31:0]       pwdata,
  output logic [31:0]            prdata,
  output logic                   pready
);

  logic [3:0] num_q, den_q;
  logic       cfg_wr;
  hlac_op_t   head;
  logic       empty, pop;

  // ratio registers; the word index is the address bit above the byte lanes
  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && pready;
  assign prdata = (paddr[2] == REG_DEN) ? 32'(den_q) : 32'(num_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      num_q <= NUM_RESET;
      den_q <= DEN_RESET;
    end else if (cfg_wr) begin
      if (paddr[2] == REG_NUM) num_q <= pwdata[3:0];
      else                     den_q <= pwdata[3:0];
    end
  end

  // front: decode and queue
  hlac_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .start_i     (start_i),
    .func_i      (func_i),
    .char_code_i (char_code_i),
    .busy_o      (busy_o),
    .pop_i       (pop),
    .head_o      (head),
    .empty_o     (empty)
  );

  // back: histogram, code build, test compare
  hlac_back #(
    .COUNT_BITS (COUNT_BITS)
  ) u_back (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .empty_i        (empty),
    .head_i         (head),
    .pop_o          (pop),
    .num_i          (num_q),
    .den_i          (den_q),
    .done_o         (done_o),
    .result_kind_o  (result_kind_o),
    .bit_total_o    (bit_total_o),
    .symbol_total_o (symbol_total_o),
    .suspicious_o   (suspicious_o),
    .status_o       (status_o)
  );

endmodule

`default_nettype wire

FILE: hdl/hlac_checker.sv
// Port-level checks for the Huffman length anomaly check, bound to the top level.
// Depends on hlac_pkg and assert_macros.svh.
`default_nettype none
`include "assert_macros.svh"

module hlac_checker import hlac_pkg::*; (
  input wire logic              clk_i,
  input wire logic              rst_ni,
  input wire logic              done_o,
  input wire logic              result_kind_o,
  input wire logic [SYMS_W-1:0] symbol_total_o,
  input wire logic              suspicious_o,
  input wire logic [1:0]        status_o
);

  // done_o never stays high into the cycle after a report
  `HLAC_ASSERT_NXT(a_done_gap, clk_i, rst_ni, done_o, !done_o)

  `HLAC_ASSERT_IMP(a_ref_not_susp, clk_i, rst_ni, done_o && (result_kind_o == KIND_REF),
    !suspicious_o)

  `HLAC_ASSERT_IMP(a_susp_has_syms, clk_i, rst_ni, done_o && suspicious_o,
    symbol_total_o != '0)

  `HLAC_ASSERT_IMP(a_empty_ref_sts, clk_i, rst_ni,
    done_o && (result_kind_o == KIND_REF) && (symbol_total_o == '0),
    (status_o == STS_EMPTY) || (status_o == STS_SAT))

endmodule

bind huffman_length_anomaly_check hlac_checker u_hlac_checker (
  .clk_i          (clk_i),
  .rst_ni         (rst_ni),
  .done_o         (done_o),
  .result_kind_o  (result_kind_o),
  .symbol_total_o (symbol_total_o),
  .suspicious_o   (suspicious_o),
  .status_o       (status_o)
);

`default_nettype wire

FILE: sim/hlac_checker.sv
// Checker for the Huffman length anomaly check: watches requests, config writes and results,
// predicts every report and compares it field by field. Depends on hlac_pkg.
`timescale 1ns / 100ps

module hlac_tb_checker import hlac_pkg::*; (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              start_i,
  input  wire logic              busy_o,
  input  wire logic [2:0]        func_i,
  input  wire logic [7:0]        char_code_i,
  input  wire logic              done_o,
  input  wire logic              result_kind_o,
  input  wire logic [BITS_W-1:0] bit_total_o,
  input  wire logic [SYMS_W-1:0] symbol_total_o,
  input  wire logic              suspicious_o,
  input  wire logic [1:0]        status_o,
  input  wire logic              psel,
  input  wire logic              penable,
  input  wire logic              pwrite,
  input  wire logic [2:0]        paddr,
  input  wire logic [31:0]       pwdata,
  input  wire logic              pready,
  output int                     errors_o,
  output int                     pending_o,
  output int                     reports_o
);

  localparam logic [BITS_W-1:0] BITS_TOP = '1;
  localparam logic [SYMS_W-1:0] SYMS_TOP = '1;
  localparam logic [31:0]       BIN_TOP  = '1;

  typedef struct packed {
    logic              kind;
    logic [BITS_W-1:0] bits;
    logic [SYMS_W-1:0] syms;
    logic              susp;
    logic [1:0]        status;
  } report_t;

  report_t     report_q[$];

  logic [3:0]  ratio_num, ratio_den;
  logic [31:0] hist[NSYM];
  logic [3:0]  code_len[NSYM];
  logic        has_code[NSYM];
  logic [BITS_W-1:0] ref_bits, tst_bits;
  logic [SYMS_W-1:0] ref_syms, tst_syms;
  logic        in_test, ref_empty, ref_sat, tst_sat, no_code;

  function automatic int hex_index(input logic [7:0] c);
    if (c >= "0" && c <= "9") return int'(c) - 48;
    if (c >= "A" && c <= "F") return int'(c) - 55;
    return -1;
  endfunction

  task automatic clear_state();
    for (int s = 0; s < NSYM; s++) begin
      hist[s] = '0;
      code_len[s] = '0;
      has_code[s] = 1'b0;
    end
    ref_bits = '0; ref_syms = '0; tst_bits = '0; tst_syms = '0;
    in_test = 0; ref_empty = 0; ref_sat = 0; tst_sat = 0; no_code = 0;
  endtask

  // Huffman build: lower weight first, leaf before merged node, then lower key.
  task automatic build_code_lengths();
    logic [63:0] w[NNODE];
    logic        leaf[NNODE], live[NNODE];
    int          key[NNODE], parent[NNODE], leaf_node[NSYM];
    int          n, alive, best, node, d;
    int          pick[2];
    n = 0;
    alive = 0;
    for (int s = 0; s < NSYM; s++) begin
      code_len[s] = '0;
      has_code[s] = 1'b0;
      leaf_node[s] = -1;
      if (hist[s] != 0) begin
        w[n] = 64'(hist[s]); leaf[n] = 1; key[n] = s; live[n] = 1; parent[n] = -1;
        leaf_node[s] = n;
        n++;
        alive++;
      end
    end
    while (alive > 1 && n < NNODE) begin
      for (int p = 0; p < 2; p++) begin
        best = -1;
        for (int k = 0; k < n; k++) begin
          if (live[k]) begin
            if (best < 0) best = k;
            else if (w[k] != w[best]) begin
              if (w[k] < w[best]) best = k;
            end else if (leaf[k] != leaf[best]) begin
              if (leaf[k]) best = k;
            end else if (key[k] < key[best]) best = k;
          end
        end
        pick[p] = best;
        live[best] = 0;
      end
      w[n] = w[pick[0]] + w[pick[1]];
      leaf[n] = 0; key[n] = n; live[n] = 1; parent[n] = -1;
      parent[pick[0]] = n;
      parent[pick[1]] = n;
      n++;
      alive--;
    end
    for (int s = 0; s < NSYM; s++) begin
      if (leaf_node[s] >= 0) begin
        node = leaf_node[s];
        d = 0;
        while (parent[node] >= 0 && d < 15) begin
          node = parent[node];
          d++;
        end
        code_len[s] = 4'(d);
        has_code[s] = 1'b1;
      end
    end
  endtask

  task automatic predict(input logic [2:0] f, input logic [7:0] c);
    int          sym;
    logic [63:0] acc_b, acc_s;
    logic [79:0] lhs, rhs;
    report_t     r;
    sym = hex_index(c);
    case (f)
      FUNC_REF_CHAR: begin
        if (!in_test && sym >= 0) begin
          if (hist[sym] == BIN_TOP) ref_sat = 1;
          else hist[sym] = hist[sym] + 1;
        end
      end
      FUNC_REF_CLOSE: begin
        if (!in_test) begin
          build_code_lengths();
          acc_b = 0;
          acc_s = 0;
          for (int s = 0; s < NSYM; s++) begin
            acc_b = acc_b + 64'(hist[s]) * code_len[s];
            if (acc_b > 64'(BITS_TOP)) begin acc_b = 64'(BITS_TOP); ref_sat = 1; end
            acc_s = acc_s + 64'(hist[s]);
            if (acc_s > 64'(SYMS_TOP)) begin acc_s = 64'(SYMS_TOP); ref_sat = 1; end
          end
          ref_bits = BITS_W'(acc_b);
          ref_syms = SYMS_W'(acc_s);
          ref_empty = (ref_syms == 0);
          in_test = 1;
          r.kind = KIND_REF;
          r.bits = ref_bits;
          r.syms = ref_syms;
          r.susp = 1'b0;
          r.status = ref_sat ? STS_SAT : (ref_empty ? STS_EMPTY : STS_OK);
          report_q.insert(report_q.size(), r);
        end
      end
      FUNC_TEST_CHAR: begin
        if (in_test && sym >= 0) begin
          if (has_code[sym]) begin
            if (BITS_TOP - tst_bits < BITS_W'(code_len[sym])) begin
              tst_bits = BITS_TOP; tst_sat = 1;
            end else tst_bits = tst_bits + code_len[sym];
          end else no_code = 1;
          if (tst_syms == SYMS_TOP) tst_sat = 1;
          else tst_syms = tst_syms + 1;
        end
      end
      FUNC_TEST_CLOSE: begin
        if (in_test) begin
          // exact integer form of test average > num/den * reference average
          lhs = 80'(ratio_den) * 80'(tst_bits) * 80'(ref_syms);
          rhs = 80'(ratio_num) * 80'(ref_bits) * 80'(tst_syms);
          r.kind = KIND_TEST;
          r.bits = tst_bits;
          r.syms = tst_syms;
          r.susp = (lhs > rhs);
          r.status = (ref_sat || tst_sat) ? STS_SAT :
                     (no_code ? STS_NO_CODE : (ref_empty ? STS_EMPTY : STS_OK));
          report_q.insert(report_q.size(), r);
          tst_bits = '0; tst_syms = '0; tst_sat = 0; no_code = 0;
        end
      end
      FUNC_CLEAR: clear_state();
      default: ;
    endcase
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    report_t e;
    if (!rst_ni) begin
      clear_state();
      ratio_num = NUM_RESET;
      ratio_den = DEN_RESET;
      report_q.delete();
      errors_o = 0;
      reports_o = 0;
    end else begin
      // result first: a report can never come from a request taken at this same edge
      if (done_o) begin
        reports_o++;
        if (report_q.size() == 0) begin
          $display("%0t: report expected none actual kind %0d bits %0d syms %0d", $realtime,
                   result_kind_o, bit_total_o, symbol_total_o);
          errors_o++;
        end else begin
          e = report_q.pop_front();
          if (result_kind_o !== e.kind) begin
            $display("%0t: kind expected %0d actual %0d", $realtime, e.kind, result_kind_o);
            errors_o++;
          end
          if (bit_total_o !== e.bits) begin
            $display("%0t: bit_total expected %0d actual %0d", $realtime, e.bits, bit_total_o);
            errors_o++;
          end
          if (symbol_total_o !== e.syms) begin
            $display("%0t: symbol_total expected %0d actual %0d", $realtime, e.syms,
                     symbol_total_o);
            errors_o++;
          end
          if (suspicious_o !== e.susp) begin
            $display("%0t: suspicious expected %0d actual %0d", $realtime, e.susp,
                     suspicious_o);
            errors_o++;
          end
          if (status_o !== e.status) begin
            $display("%0t: status expected %0d actual %0d", $realtime, e.status, status_o);
            errors_o++;
          end
        end
      end
      if (psel && penable && pwrite && pready) begin
        if (paddr[2] == REG_NUM) ratio_num = pwdata[3:0];
        else ratio_den = pwdata[3:0];
      end
      if (start_i && !busy_o) predict(func_i, char_code_i);
    end
    pending_o = report_q.size();
  end

endmodule

FILE: sim/huffman_length_anomaly_check_tb.sv
// Testbench top for the Huffman length anomaly check: clock, reset, request and config stimulus.
// Depends on hlac_pkg, huffman_length_anomaly_check and hlac_tb_checker.
`timescale 1ns / 100ps

module huffman_length_anomaly_check_tb;
  import hlac_pkg::*;

  localparam logic [2:0] ADDR_NUM = {REG_NUM, 2'b00};
  localparam logic [2:0] ADDR_DEN = {REG_DEN, 2'b00};
  localparam int unsigned ITEM_GOAL = 1250;
  localparam int unsigned QUIET_FROM = 1100;   // no idling past this point
  localparam int unsigned DRAIN_CYCLES = 1000; // longer than a 16-symbol build

  logic              clk_i = 1'b0;
  logic              rst_ni = 1'b0;
  logic              start_i;
  logic [2:0]        func_i;
  logic [7:0]        char_code_i;
  logic              psel, penable, pwrite;
  logic [2:0]        paddr;
  logic [31:0]       pwdata;
  logic              busy_o, done_o, result_kind_o, suspicious_o, pready;
  logic [BITS_W-1:0] bit_total_o;
  logic [SYMS_W-1:0] symbol_total_o;
  logic [1:0]        status_o;
  logic [31:0]       prdata;
  int                errors, pending, reports;
  int                requests = 0;
  int                settings = 0;
  bit                idling = 1'b1;

  always #6 clk_i = ~clk_i;

  huffman_length_anomaly_check dut (
    .clk_i, .rst_ni, .start_i, .busy_o, .func_i, .char_code_i, .done_o, .result_kind_o,
    .bit_total_o, .symbol_total_o, .suspicious_o, .status_o,
    .psel, .penable, .pwrite, .paddr, .pwdata, .prdata, .pready
  );

  hlac_tb_checker chk (
    .clk_i, .rst_ni, .start_i, .busy_o, .func_i, .char_code_i, .done_o, .result_kind_o,
    .bit_total_o, .symbol_total_o, .suspicious_o, .status_o,
    .psel, .penable, .pwrite, .paddr, .pwdata, .pready,
    .errors_o(errors), .pending_o(pending), .reports_o(reports)
  );

  function automatic logic [7:0] hex_char(input int idx);
    return (idx < 10) ? 8'(48 + idx) : 8'(55 + idx);
  endfunction

  // One request; returns at its taking edge or after an idle gap. start stays high back to back.
  task automatic send(input logic [2:0] f, input logic [7:0] c);
    start_i <= 1'b1;
    func_i <= f;
    char_code_i <= c;
    @(posedge clk_i);
    while (busy_o) @(posedge clk_i);
    requests++;
    if (idling && $urandom_range(0, 4) == 0) begin
      start_i <= 1'b0;
      func_i <= 3'($urandom);
      char_code_i <= 8'($urandom);
      repeat ($urandom_range(1, 4)) @(posedge clk_i);
    end
  endtask

  // Sender pause until every report is in, plus room for a build still running.
  task automatic drain();
    start_i <= 1'b0;
    @(posedge clk_i);
    while (pending != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
  endtask

  task automatic apb_write(input logic [2:0] a, input logic [31:0] d);
    psel <= 1'b1; penable <= 1'b0; pwrite <= 1'b1; paddr <= a; pwdata <= d;
    @(posedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    psel <= 1'b0; penable <= 1'b0; pwrite <= 1'b0;
    @(posedge clk_i);
  endtask

  task automatic set_ratio(input logic [3:0] n, input logic [3:0] d);
    drain();
    apb_write(ADDR_NUM, ($urandom & 32'hFFFF_FFF0) | 32'(n));
    apb_write(ADDR_DEN, ($urandom & 32'hFFFF_FFF0) | 32'(d));
    settings++;
  endtask

  // Well-formed session: a clear most times, skewed reference, close, a few tests; some noise mixed in.
  task automatic session();
    int w[NSYM];
    int used, pick, total, r;
    if ($urandom_range(0, 9) != 0) send(FUNC_CLEAR, 8'($urandom));
    used = $urandom_range(0, 15);
    for (int s = 0; s < NSYM; s++)
      w[s] = ($urandom_range(0, 15) <= used) ? $urandom_range(1, 6) : 0;
    if ($urandom_range(0, 11) == 0) for (int s = 0; s < NSYM; s++) w[s] = 0;
    for (int s = 0; s < NSYM; s++) begin
      for (int k = 0; k < w[s]; k++) begin
        if ($urandom_range(0, 9) == 0) send(FUNC_REF_CHAR, 8'($urandom));
        if ($urandom_range(0, 29) == 0) send(FUNC_TEST_CHAR, hex_char(s));
        send(FUNC_REF_CHAR, hex_char(s));
      end
    end
    send(FUNC_REF_CLOSE, 8'($urandom));
    repeat ($urandom_range(1, 4)) begin
      total = $urandom_range(0, 20);
      for (int k = 0; k < total; k++) begin
        r = $urandom_range(0, 19);
        pick = $urandom_range(0, 15);
        if (r == 0) send(FUNC_TEST_CHAR, 8'($urandom));
        else if (r == 1) send(FUNC_REF_CHAR, hex_char(pick));
        else if (r == 2) send(3'($urandom_range(5, 7)), 8'($urandom));
        else if (r < 12 && w[pick] == 0) send(FUNC_TEST_CHAR, hex_char((pick + 3) % NSYM));
        else send(FUNC_TEST_CHAR, hex_char(pick));
      end
      if ($urandom_range(0, 15) == 0) send(FUNC_REF_CLOSE, 8'($urandom));
      send(FUNC_TEST_CLOSE, 8'($urandom));
    end
  endtask

  initial begin
    start_i <= 1'b0; func_i <= '0; char_code_i <= '0;
    psel <= 1'b0; penable <= 1'b0; pwrite <= 1'b0; paddr <= '0; pwdata <= '0;
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // directed: test items before any reference, empty reference, code-less test symbol
    send(FUNC_TEST_CHAR, "7");
    send(FUNC_TEST_CLOSE, 8'h00);
    send(FUNC_REF_CLOSE, 8'hFF);
    send(FUNC_TEST_CHAR, "F");
    send(FUNC_TEST_CLOSE, 8'h00);
    // single present symbol gets length zero; range edges of the hex digits and neighbors
    send(FUNC_CLEAR, 8'h00);
    for (int k = 0; k < 3; k++) send(FUNC_REF_CHAR, "5");
    send(FUNC_REF_CHAR, 8'h2F); send(FUNC_REF_CHAR, 8'h3A);
    send(FUNC_REF_CHAR, 8'h40); send(FUNC_REF_CHAR, 8'h47);
    send(FUNC_REF_CLOSE, 8'h00);
    send(FUNC_TEST_CHAR, "5");
    send(FUNC_TEST_CLOSE, 8'h00);
    send(FUNC_TEST_CLOSE, 8'h00);   // empty test
    send(3'd5, 8'hFF); send(3'd6, 8'h00); send(3'd7, 8'hAA);
    send(FUNC_CLEAR, 8'h00);
    send(FUNC_REF_CHAR, "0"); send(FUNC_REF_CHAR, "9");
    send(FUNC_REF_CHAR, "A"); send(FUNC_REF_CHAR, "F"); send(FUNC_REF_CHAR, "F");
    send(FUNC_REF_CLOSE, 8'h00);
    send(FUNC_TEST_CHAR, "0"); send(FUNC_TEST_CHAR, "9");
    send(FUNC_TEST_CLOSE, 8'h00);

    // random part, one ratio setting per block of sessions, extremes and zeros included
    while (requests < ITEM_GOAL) begin
      case (settings % 8)
        0: set_ratio(4'd1, 4'd1);
        1: set_ratio(4'd15, 4'd15);
        2: set_ratio(4'd15, 4'd1);
        3: set_ratio(4'd1, 4'd15);
        4: set_ratio(4'd0, 4'd2);
        5: set_ratio(4'd3, 4'd0);
        6: set_ratio(NUM_RESET, DEN_RESET);
        default: set_ratio(4'($urandom_range(1, 15)), 4'($urandom_range(1, 15)));
      endcase
      for (int k = 0; k < 4 && requests < ITEM_GOAL; k++) begin
        idling = (requests < QUIET_FROM);
        session();
      end
    end

    drain();
    $display("Covered %0d requests and %0d reports over %0d ratio settings.",
             requests, reports, settings);
    if (errors == 0) $display("SCOREBOARD CLEAN");
    else $display("SCOREBOARD MISMATCH");
    $finish;
  end

  initial begin
    #(12 * 10_000_000);
    $display("SCOREBOARD MISMATCH");
    $finish;
  end

endmodule

FILE: sim.f
+incdir+hdl
hdl/hlac_pkg.sv
hdl/hlac_front.sv
hdl/hlac_back.sv
hdl/huffman_length_anomaly_check.sv
hdl/hlac_checker.sv
sim/hlac_checker.sv
sim/huffman_length_anomaly_check_tb.sv
